// ===== src/upsdec_pkg.sv =====
// shared types and constants for the ups status frame decoder
package upsdec_pkg;

	localparam int FRAME_BYTES = 14;
	localparam int POS_W       = $clog2(FRAME_BYTES);

	typedef logic [POS_W-1:0] pos_t;

	// byte positions inside the reply frame
	localparam pos_t IDX_START    = pos_t'(0);
	localparam pos_t IDX_IN_VOLT  = pos_t'(1);
	localparam pos_t IDX_OUT_VOLT = pos_t'(2);
	localparam pos_t IDX_LOAD     = pos_t'(3);
	localparam pos_t IDX_CHARGE   = pos_t'(5);
	localparam pos_t IDX_TEMP     = pos_t'(6);
	localparam pos_t IDX_FREQ     = pos_t'(7);
	localparam pos_t IDX_FLAG0    = pos_t'(9);
	localparam pos_t IDX_FLAG1    = pos_t'(10);
	localparam pos_t IDX_FLAG2    = pos_t'(11);
	localparam pos_t IDX_FLAG3    = pos_t'(12);
	localparam pos_t IDX_LAST     = pos_t'(FRAME_BYTES - 1);

	// frequency divider: quotient, divisor and counter widths, numerator and offset of the op formula
	localparam int QUO_W    = 12;
	localparam int DVS_W    = 9;
	localparam int CNT_W    = $clog2(QUO_W + 1);
	localparam int FREQ_NUM = 126000;
	localparam int FREQ_OFS = 32;

	typedef struct packed {
		logic wr_en;
		pos_t wr_idx;
		logic div_init;
		logic div_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_stat_t;

endpackage

// ===== src/upsdec_rx_if.sv =====
// byte input channel
interface upsdec_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== src/upsdec_res_if.sv =====
// decoded result channel
interface upsdec_res_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic [7:0]  input_voltage;
	logic [7:0]  output_voltage;
	logic [8:0]  load_percent;
	logic [7:0]  battery_charge;
	logic [11:0] temperature_tenths;
	logic [11:0] frequency_tenths;
	logic [6:0]  status_bits;

	modport source (output valid, output frame_ok, output input_voltage,
		output output_voltage, output load_percent, output battery_charge,
		output temperature_tenths, output frequency_tenths, output status_bits,
		input ready);
	modport sink (input valid, input frame_ok, input input_voltage,
		input output_voltage, input load_percent, input battery_charge,
		input temperature_tenths, input frequency_tenths, input status_bits,
		output ready);
endinterface

// ===== src/upsdec_cfg_if.sv =====
// configuration write channel
interface upsdec_cfg_if;
	logic valid;
	logic ready;
	logic series_mode;

	modport source (output valid, output series_mode, input ready);
	modport sink (input valid, input series_mode, output ready);
endinterface

// ===== src/upsdec_dp.sv =====
// datapath: frame byte registers, scaling pipeline, frequency divider, result register
module upsdec_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  upsdec_pkg::cmd_t     cmd,
	output upsdec_pkg::dp_stat_t status,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_wr,
	input  logic                 cfg_mode,
	output logic                 frame_ok,
	output logic [7:0]           input_voltage,
	output logic [7:0]           output_voltage,
	output logic [8:0]           load_percent,
	output logic [7:0]           battery_charge,
	output logic [11:0]          temperature_tenths,
	output logic [11:0]          frequency_tenths,
	output logic [6:0]           status_bits
);

	localparam int VOLT_RECIP = 56987;   // floor(20 * 2^16 / 23)
	localparam int VOLT_MIN   = 27;
	localparam int VOLT_OFS   = 6;
	localparam int CHG_HI     = 185;
	localparam int CHG_LO     = 160;
	localparam int CHG_FULL   = 100;
	localparam int CHG_SCALE  = 10000;
	localparam int TEMP_BASE  = 100;
	localparam int DVS_W      = upsdec_pkg::DVS_W;
	localparam logic [7:0] FLAG_BEEP    = 8'h01;
	localparam logic [7:0] FLAG_ON_BATT = 8'h80;
	localparam logic [7:0] FLAG_LOW_BAT = 8'h40;
	localparam logic [7:0] FLAG_TEST    = 8'h04;
	localparam logic [7:0] FLAG_NO_AVR  = 8'h84;

	logic series_mode_q;
	logic [7:0] iv_q, ov_q, ld_q, ch_q, tp_q, fq_q, f0_q, f1_q, f2_q, f3_q;

	// pipeline registers, free running over the held frame bytes
	logic [7:0]  iv_est_s1, ov_est_s1;
	logic [15:0] tsq_s1;
	logic [9:0]  dsq_s1;
	logic        boost_s1, trim_s1;
	logic [7:0]  iv_op_s2, ov_op_s2, chg_op_s2;
	logic [11:0] temp_op_s2;

	// divider
	logic [DVS_W-1:0]             rem_q, dvs_q;
	logic [upsdec_pkg::QUO_W-1:0] quot_q, lo_q;
	logic [upsdec_pkg::CNT_W-1:0] cnt_q;

	logic [23:0] iv_prod, ov_prod, chg_prod;
	logic [4:0]  chg_d;
	logic [19:0] tn;
	logic [9:0]  tq, tr;
	logic        tinc;
	logic [DVS_W:0] div_t, dvs_ext, two_r;
	logic        div_ge, finc;
	logic        frame_good, no_avr;
	logic [6:0]  st;

	function automatic logic [7:0] op_volt(input logic [7:0] raw, input logic [7:0] est);
		logic [12:0] rem;
		logic [7:0]  q;
		rem = 13'(raw) * 13'(20) - 13'(est) * 13'(23);
		q   = (rem >= 13'(23)) ? est + 8'd1 : est;
		return (raw < 8'(VOLT_MIN)) ? 8'd0 : q + 8'(VOLT_OFS);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			series_mode_q <= cfg_mode;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			unique case (cmd.wr_idx)
				upsdec_pkg::IDX_IN_VOLT:  iv_q <= rx_byte;
				upsdec_pkg::IDX_OUT_VOLT: ov_q <= rx_byte;
				upsdec_pkg::IDX_LOAD:     ld_q <= rx_byte;
				upsdec_pkg::IDX_CHARGE:   ch_q <= rx_byte;
				upsdec_pkg::IDX_TEMP:     tp_q <= rx_byte;
				upsdec_pkg::IDX_FREQ:     fq_q <= rx_byte;
				upsdec_pkg::IDX_FLAG0:    f0_q <= rx_byte;
				upsdec_pkg::IDX_FLAG1:    f1_q <= rx_byte;
				upsdec_pkg::IDX_FLAG2:    f2_q <= rx_byte;
				upsdec_pkg::IDX_FLAG3:    f3_q <= rx_byte;
				default: ;
			endcase
		end
	end

	// stage 1: reciprocal estimates, squares and boost/trim compares
	assign iv_prod = 24'(iv_q) * 24'(VOLT_RECIP);
	assign ov_prod = 24'(ov_q) * 24'(VOLT_RECIP);
	assign chg_d   = 5'(ch_q - 8'(CHG_LO));

	always_ff @(posedge clk) begin
		iv_est_s1 <= iv_prod[23:16];
		ov_est_s1 <= ov_prod[23:16];
		tsq_s1    <= 16'(tp_q) * 16'(tp_q);
		dsq_s1    <= 10'(chg_d) * 10'(chg_d);
		boost_s1  <= ({1'b0, iv_q, 1'b0} > {2'b00, ov_q})
			&& (15'(iv_q) * 15'(100) < 15'(ov_q) * 15'(98));
		trim_s1   <= ({1'b0, ov_q, 1'b0} > {2'b00, iv_q})
			&& (15'(ov_q) * 15'(100) < 15'(iv_q) * 15'(98));
	end

	// stage 2: corrections, scaling and rounding
	assign tn       = 20'(tsq_s1) * 20'(10);
	assign tq       = tn[19:10];
	assign tr       = tn[9:0];
	assign tinc     = (tr > 10'd512) || ((tr == 10'd512) && tq[0]);
	assign chg_prod = 24'(dsq_s1) * 24'(CHG_SCALE);

	always_ff @(posedge clk) begin
		iv_op_s2   <= op_volt(iv_q, iv_est_s1);
		ov_op_s2   <= op_volt(ov_q, ov_est_s1);
		temp_op_s2 <= 12'(tq) + 12'(tinc) + 12'(TEMP_BASE);
		if (ch_q > 8'(CHG_HI)) begin
			chg_op_s2 <= 8'(CHG_FULL);
		end else if (ch_q < 8'(CHG_LO)) begin
			chg_op_s2 <= 8'd0;
		end else begin
			chg_op_s2 <= chg_prod[23:16];
		end
	end

	// restoring divider, one quotient bit per step
	assign dvs_ext = {1'b0, dvs_q};
	assign div_t   = {rem_q, lo_q[upsdec_pkg::QUO_W-1]};
	assign div_ge  = (div_t >= dvs_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= upsdec_pkg::CNT_W'(upsdec_pkg::QUO_W);
		end else if (cmd.div_step && (cnt_q != '0)) begin
			cnt_q <= cnt_q - upsdec_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= DVS_W'(upsdec_pkg::FREQ_NUM >> upsdec_pkg::QUO_W);
			lo_q   <= upsdec_pkg::QUO_W'(upsdec_pkg::FREQ_NUM);
			dvs_q  <= DVS_W'(fq_q) + DVS_W'(upsdec_pkg::FREQ_OFS);
			quot_q <= '0;
		end else if (cmd.div_step && (cnt_q != '0)) begin
			rem_q  <= div_ge ? DVS_W'(div_t - dvs_ext) : DVS_W'(div_t);
			lo_q   <= {lo_q[upsdec_pkg::QUO_W-2:0], 1'b0};
			quot_q <= {quot_q[upsdec_pkg::QUO_W-2:0], div_ge};
		end
	end

	assign status.div_done = (cnt_q == '0);

	// round half to even on the final remainder
	assign two_r = {rem_q, 1'b0};
	assign finc  = (two_r > dvs_ext) || ((two_r == dvs_ext) && quot_q[0]);

	assign frame_good = ((9'(f0_q) + 9'(f1_q)) == 9'd255) && ((9'(f2_q) + 9'(f3_q)) == 9'd255);
	assign no_avr     = ((f0_q & FLAG_NO_AVR) == 8'h00);

	always_comb begin
		st    = '0;
		st[0] = |(f0_q & FLAG_BEEP);
		st[1] = |(f0_q & FLAG_ON_BATT);
		st[2] = |(f0_q & FLAG_LOW_BAT);
		st[3] = no_avr && boost_s1;
		st[4] = no_avr && trim_s1;
		st[5] = |(f0_q & FLAG_TEST);
		st[6] = (f0_q == 8'h00);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (!frame_good) begin
				frame_ok           <= 1'b0;
				input_voltage      <= '0;
				output_voltage     <= '0;
				load_percent       <= '0;
				battery_charge     <= '0;
				temperature_tenths <= '0;
				frequency_tenths   <= '0;
				status_bits        <= '0;
			end else if (series_mode_q) begin
				frame_ok           <= 1'b1;
				input_voltage      <= iv_op_s2;
				output_voltage     <= ov_op_s2;
				load_percent       <= {ld_q, 1'b0};
				battery_charge     <= chg_op_s2;
				temperature_tenths <= temp_op_s2;
				frequency_tenths   <= quot_q + 12'(finc);
				status_bits        <= st;
			end else begin
				frame_ok           <= 1'b1;
				input_voltage      <= iv_q;
				output_voltage     <= ov_q;
				load_percent       <= {1'b0, ld_q};
				battery_charge     <= ch_q;
				temperature_tenths <= 12'(tp_q) * 12'(10);
				frequency_tenths   <= {2'b00, fq_q, 2'b00};
				status_bits        <= st;
			end
		end
	end

endmodule

// ===== src/upsdec_ctrl.sv =====
// controller: byte position, decode sequencing and result valid
module upsdec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_frame_start,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output upsdec_pkg::cmd_t     cmd,
	input  upsdec_pkg::dp_stat_t status
);

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

	state_t             state_q;
	upsdec_pkg::pos_t   pos_q;
	logic               out_valid_q;
	logic               in_acc, out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.wr_en    = in_acc && (in_frame_start || (pos_q != upsdec_pkg::IDX_START));
		cmd.wr_idx   = in_frame_start ? upsdec_pkg::IDX_START : pos_q;
		cmd.div_init = cmd.wr_en && (cmd.wr_idx == upsdec_pkg::IDX_LAST);
		cmd.div_step = (state_q == S_BUSY) && !status.div_done;
		cmd.load     = (state_q == S_BUSY) && status.div_done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= upsdec_pkg::IDX_START;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd.div_init) begin
						pos_q   <= upsdec_pkg::IDX_START;
						state_q <= S_BUSY;
					end else if (cmd.wr_en) begin
						pos_q <= cmd.wr_idx + upsdec_pkg::pos_t'(1);
					end
				end
				S_BUSY: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/ups_status_frame_decoder.sv =====
// top level of the ups status frame decoder
// bytes 0..12 of a frame: one request per cycle while the block is idle, no result
// last byte: starts the decode, input held off until its result is loaded
// the decode runs the 12 step frequency divider, then loads the result once the output register is free
// a finished result waits in the output register while the next frame streams in
// reset clears byte position, sequencer, result valid and series mode; byte store unset
module ups_status_frame_decoder (
	input  logic          clk,
	input  logic          arst_n,
	upsdec_rx_if.sink     rx,
	upsdec_res_if.source  res,
	upsdec_cfg_if.sink    cfg
);

	upsdec_pkg::cmd_t     cmd;
	upsdec_pkg::dp_stat_t status;

	// config register always takes the write
	assign cfg.ready = 1'b1;

	// sequencer: tracks position in the frame and runs the decode
	upsdec_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (rx.valid),
		.in_frame_start (rx.frame_start),
		.in_ready       (rx.ready),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.cmd            (cmd),
		.status         (status)
	);

	// datapath: byte registers, scaling pipeline, divider and result register
	upsdec_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.rx_byte            (rx.rx_byte),
		.cfg_wr             (cfg.valid),
		.cfg_mode           (cfg.series_mode),
		.frame_ok           (res.frame_ok),
		.input_voltage      (res.input_voltage),
		.output_voltage     (res.output_voltage),
		.load_percent       (res.load_percent),
		.battery_charge     (res.battery_charge),
		.temperature_tenths (res.temperature_tenths),
		.frequency_tenths   (res.frequency_tenths),
		.status_bits        (res.status_bits)
	);

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!res.valid || res.ready))
		else $error("result register overwritten");

	// after the last byte the input is held off for the decode
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> !rx.ready)
		else $error("input open during decode");

	// a failed checksum gives an all zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.frame_ok) |-> (res.input_voltage == 8'd0
			&& res.frequency_tenths == 12'd0 && res.status_bits == 7'd0))
		else $error("failed frame with nonzero fields");

	// scaled values stay within their ranges
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.frequency_tenths <= 12'd3938
			&& res.temperature_tenths <= 12'd2550))
		else $error("result out of range");

endmodule

// ===== verif/tb.sv =====
// self-checking bench for the ups status frame decoder: directed frames then random traffic
`timescale 1ns / 1ps

module tb;

	// series mode register values
	localparam logic MODE_DEFAULT = 1'b0;
	localparam logic MODE_OP      = 1'b1;

	// flag byte 0 bits
	localparam logic [7:0] FLAG_BEEP     = 8'h01;
	localparam logic [7:0] FLAG_TEST     = 8'h04;
	localparam logic [7:0] FLAG_LOW_BATT = 8'h40;
	localparam logic [7:0] FLAG_ON_BATT  = 8'h80;

	// status_bits positions
	localparam int ST_BEEP     = 0;
	localparam int ST_ON_BATT  = 1;
	localparam int ST_LOW_BATT = 2;
	localparam int ST_BOOST    = 3;
	localparam int ST_TRIM     = 4;
	localparam int ST_TEST     = 5;
	localparam int ST_OFF      = 6;

	// op series scaling constants
	localparam int unsigned VOLT_FLOOR_RAW   = 27;
	localparam int unsigned CHARGE_FULL_RAW  = 185;
	localparam int unsigned CHARGE_EMPTY_RAW = 160;
	localparam int unsigned TEMP_BASE        = 100;
	localparam int unsigned TEMP_DIV         = 1024;
	localparam int unsigned FREQ_NUMER       = 126000;
	localparam int unsigned FREQ_BIAS        = 32;

	// bytes of the frame that carry nothing
	localparam int FILL_A = 4;
	localparam int FILL_B = 8;
	localparam logic [7:0] FRAME_SOF = 8'h23;
	localparam logic [7:0] FRAME_EOF = 8'h0D;

	// settle time after the last owed decode comes out, a good deal longer than a decode
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1400;
	localparam int PHASES       = 6;

	typedef struct packed {
		logic        frame_ok;
		logic [7:0]  input_voltage;
		logic [7:0]  output_voltage;
		logic [8:0]  load_percent;
		logic [7:0]  battery_charge;
		logic [11:0] temperature_tenths;
		logic [11:0] frequency_tenths;
		logic [6:0]  status_bits;
	} decode_t;

	// what goes in ahead of a directed frame
	typedef enum logic [1:0] {LEAD_NONE, LEAD_STRAY, LEAD_RESTART} lead_t;

	typedef struct {
		logic       mode;
		lead_t      lead;
		logic [7:0] iv, ov, ld, ch, tp, fq;
		logic [7:0] f0, f1, f2, f3;
		logic       typed;
		decode_t    want;
	} dir_row_t;

	localparam int DIR_ROWS = 12;

	// directed frames; typed rows carry the decode read straight off the spec
	dir_row_t dir_rows [DIR_ROWS] = '{
		// all zero, off bit only, after a stray byte that must be dropped
		'{MODE_DEFAULT, LEAD_STRAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
			8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, '{1'b1, 8'd0, 8'd0, 9'd0, 8'd0, 12'd0, 12'd0, 7'h40}},
		// all ones, raw maximum on every field
		'{MODE_DEFAULT, LEAD_NONE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1,
			'{1'b1, 8'd255, 8'd255, 9'd255, 8'd255, 12'd2550, 12'd1020, 7'h27}},
		// first checksum pair broken
		'{MODE_DEFAULT, LEAD_NONE, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60,
			8'h12, 8'h00, 8'h00, 8'hFF, 1'b1, '0},
		// second checksum pair broken
		'{MODE_DEFAULT, LEAD_NONE, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60,
			8'h00, 8'hFF, 8'h01, 8'h01, 1'b1, '0},
		// test flag masks the boost compare, partial frame dropped first
		'{MODE_DEFAULT, LEAD_RESTART, 8'd100, 8'd110, 8'd45, 8'd186, 8'd30, 8'd50,
			8'h04, 8'hFB, 8'h00, 8'hFF, 1'b0, '0},
		// on battery masks the boost compare
		'{MODE_DEFAULT, LEAD_NONE, 8'd100, 8'd110, 8'd45, 8'd170, 8'd30, 8'd50,
			8'h80, 8'h7F, 8'h00, 8'hFF, 1'b0, '0},
		// op series at the top of every field
		'{MODE_OP, LEAD_NONE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1,
			'{1'b1, 8'd227, 8'd227, 9'd510, 8'd100, 12'd735, 12'd439, 7'h27}},
		// op series at zero: frequency lands on a tie
		'{MODE_OP, LEAD_NONE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
			8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1,
			'{1'b1, 8'd0, 8'd0, 9'd0, 8'd0, 12'd100, 12'd3938, 7'h40}},
		// voltage floor edges, boost, temperature tie, charge just below range
		'{MODE_OP, LEAD_NONE, 8'd26, 8'd27, 8'd100, 8'd159, 8'd16, 8'd93,
			8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
		// trim with beeper, bottom of charge range, restart inside a frame
		'{MODE_OP, LEAD_RESTART, 8'd120, 8'd110, 8'd77, 8'd160, 8'd32, 8'd168,
			8'h01, 8'hFE, 8'h00, 8'hFF, 1'b0, '0},
		// low battery, equal voltages, top of charge range
		'{MODE_OP, LEAD_STRAY, 8'd230, 8'd230, 8'd200, 8'd185, 8'd200, 8'd0,
			8'h40, 8'hBF, 8'h5A, 8'hA5, 1'b0, '0},
		// at the voltage floor, charge just in range
		'{MODE_OP, LEAD_NONE, 8'd27, 8'd100, 8'd1, 8'd161, 8'd255, 8'd255,
			8'hC0, 8'h3F, 8'h00, 8'hFF, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	upsdec_rx_if  rx_ch ();
	upsdec_res_if res_ch ();
	upsdec_cfg_if cfg_ch ();

	ups_status_frame_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor state: byte position, frame image and series mode
	int         rx_pos = 0;
	logic [7:0] rx_frame [upsdec_pkg::FRAME_BYTES];
	logic       cur_mode = MODE_DEFAULT;

	// decodes still owed by the block, oldest first
	decode_t expected_decodes [$];
	logic    use_typed = 1'b0;
	decode_t typed_value;

	int bytes_taken   = 0;
	int mismatches    = 0;
	int cycle_count   = 0;
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic int unsigned div_nearest_even(input int unsigned n, input int unsigned d);
		int unsigned q;
		int unsigned r;
		q = n / d;
		r = n % d;
		if (2 * r > d || (2 * r == d && q[0]))
			q++;
		return q;
	endfunction

	function automatic logic [7:0] op_volts(input int unsigned raw);
		if (raw < VOLT_FLOOR_RAW)
			return 8'd0;
		return 8'(raw * 20 / 23 + 6);
	endfunction

	function automatic logic [7:0] op_charge(input int unsigned raw);
		int unsigned d;
		if (raw > CHARGE_FULL_RAW)
			return 8'd100;
		if (raw < CHARGE_EMPTY_RAW)
			return 8'd0;
		d = raw - CHARGE_EMPTY_RAW;
		return 8'(d * d * 10000 / 65536);
	endfunction

	function automatic decode_t decode_status_frame(
		input logic [7:0] fb [upsdec_pkg::FRAME_BYTES], input logic mode);
		decode_t     d;
		int unsigned iv, ov, ld, ch, tp, fq, f0, f1, f2, f3;
		d  = '0;
		iv = fb[upsdec_pkg::IDX_IN_VOLT];
		ov = fb[upsdec_pkg::IDX_OUT_VOLT];
		ld = fb[upsdec_pkg::IDX_LOAD];
		ch = fb[upsdec_pkg::IDX_CHARGE];
		tp = fb[upsdec_pkg::IDX_TEMP];
		fq = fb[upsdec_pkg::IDX_FREQ];
		f0 = fb[upsdec_pkg::IDX_FLAG0];
		f1 = fb[upsdec_pkg::IDX_FLAG1];
		f2 = fb[upsdec_pkg::IDX_FLAG2];
		f3 = fb[upsdec_pkg::IDX_FLAG3];
		// a broken checksum pair zeroes the whole decode
		if (f0 + f1 != 255 || f2 + f3 != 255)
			return d;
		d.frame_ok = 1'b1;
		if (mode == MODE_OP) begin
			d.input_voltage      = op_volts(iv);
			d.output_voltage     = op_volts(ov);
			d.load_percent       = 9'(ld * 2);
			d.battery_charge     = op_charge(ch);
			d.temperature_tenths = 12'(TEMP_BASE + div_nearest_even(tp * tp * 10, TEMP_DIV));
			d.frequency_tenths   = 12'(div_nearest_even(FREQ_NUMER, fq + FREQ_BIAS));
		end else begin
			d.input_voltage      = 8'(iv);
			d.output_voltage     = 8'(ov);
			d.load_percent       = 9'(ld);
			d.battery_charge     = 8'(ch);
			d.temperature_tenths = 12'(tp * 10);
			d.frequency_tenths   = 12'(fq * 4);
		end
		d.status_bits[ST_BEEP]     = (f0 & FLAG_BEEP) != 0;
		d.status_bits[ST_ON_BATT]  = (f0 & FLAG_ON_BATT) != 0;
		d.status_bits[ST_LOW_BATT] = (f0 & FLAG_LOW_BATT) != 0;
		// boost and trim only count while on line and not self testing
		if ((f0 & (FLAG_ON_BATT | FLAG_TEST)) == 0) begin
			d.status_bits[ST_BOOST] = (2 * iv > ov) && (100 * iv < 98 * ov);
			d.status_bits[ST_TRIM]  = (2 * ov > iv) && (100 * ov < 98 * iv);
		end
		d.status_bits[ST_TEST] = (f0 & FLAG_TEST) != 0;
		d.status_bits[ST_OFF]  = (f0 == 0);
		return d;
	endfunction

	// one accepted byte request through the predictor
	task automatic take_byte(input logic [7:0] b, input logic st);
		if (st)
			rx_pos = 0;
		else if (rx_pos == 0)
			return;  // no frame open, block drops it
		rx_frame[rx_pos] = b;
		rx_pos++;
		bytes_taken++;
		if (rx_pos == upsdec_pkg::FRAME_BYTES) begin
			rx_pos = 0;
			expected_decodes.push_back(use_typed ? typed_value
				: decode_status_frame(rx_frame, cur_mode));
		end
	endtask

	// ---------------------------------------------------------------
	// byte source
	// ---------------------------------------------------------------

	// valid stays up between back to back requests, dropped only for a gap or a drain
	task automatic send_byte(input logic [7:0] b, input logic st);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		rx_ch.valid       <= 1'b1;
		rx_ch.rx_byte     <= b;
		rx_ch.frame_start <= st;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		take_byte(b, st);
	endtask

	task automatic send_frame(input logic [7:0] fb [upsdec_pkg::FRAME_BYTES]);
		for (int k = 0; k < upsdec_pkg::FRAME_BYTES; k++)
			send_byte(fb[k], k == 0);
	endtask

	function automatic void fill_frame(output logic [7:0] fb [upsdec_pkg::FRAME_BYTES],
		input logic [7:0] iv, ov, ld, ch, tp, fq, f0, f1, f2, f3);
		fb[upsdec_pkg::IDX_START]    = FRAME_SOF;
		fb[upsdec_pkg::IDX_IN_VOLT]  = iv;
		fb[upsdec_pkg::IDX_OUT_VOLT] = ov;
		fb[upsdec_pkg::IDX_LOAD]     = ld;
		fb[FILL_A]                   = 8'h00;
		fb[upsdec_pkg::IDX_CHARGE]   = ch;
		fb[upsdec_pkg::IDX_TEMP]     = tp;
		fb[upsdec_pkg::IDX_FREQ]     = fq;
		fb[FILL_B]                   = 8'h00;
		fb[upsdec_pkg::IDX_FLAG0]    = f0;
		fb[upsdec_pkg::IDX_FLAG1]    = f1;
		fb[upsdec_pkg::IDX_FLAG2]    = f2;
		fb[upsdec_pkg::IDX_FLAG3]    = f3;
		fb[upsdec_pkg::IDX_LAST]     = FRAME_EOF;
	endfunction

	// measurement byte, leaning on the thresholds of the op formulas
	function automatic logic [7:0] pick_level();
		logic [7:0] corner_vals [12] = '{8'd0, 8'd1, 8'd26, 8'd27, 8'd28, 8'd159,
			8'd160, 8'd161, 8'd185, 8'd186, 8'd254, 8'd255};
		if ($urandom_range(0, 3) == 0)
			return corner_vals[$urandom_range(0, 11)];
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_flag();
		logic [7:0] flag_vals [8] = '{8'h00, FLAG_BEEP, FLAG_TEST, FLAG_LOW_BATT,
			FLAG_ON_BATT, 8'h84, 8'hC1, 8'hFF};
		if ($urandom_range(0, 2) == 0)
			return flag_vals[$urandom_range(0, 7)];
		return 8'($urandom);
	endfunction

	// hold off new requests until every owed decode has come out
	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		while (expected_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// series mode changes only with the block idle
	task automatic write_mode(input logic m);
		drain_results();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.series_mode <= m;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		cur_mode = m;
	endtask

	// mostly good frames with random content, some broken or noisy
	task automatic send_random_frame();
		logic [7:0] fb [upsdec_pkg::FRAME_BYTES];
		logic [7:0] iv, ov, f0, f1, f2, f3;
		int         kind;
		int         cut;
		kind = $urandom_range(0, 99);
		if ($urandom_range(0, 24) == 0)
			drain_results();
		iv = pick_level();
		// nearby voltages probe the boost and trim compares
		if ($urandom_range(0, 1) == 0)
			ov = 8'(int'(iv) + int'($urandom_range(0, 16)) - 8);
		else
			ov = pick_level();
		f0 = pick_flag();
		f2 = pick_flag();
		f1 = ~f0;
		f3 = ~f2;
		if (kind >= 70 && kind < 82) begin
			// single bit flip always breaks the pair sum
			if ($urandom_range(0, 1) == 0)
				f1 = f1 ^ (8'h01 << $urandom_range(0, 7));
			else
				f3 = f3 ^ (8'h01 << $urandom_range(0, 7));
		end else if (kind >= 82 && kind < 86) begin
			f1 = 8'($urandom);
			f3 = 8'($urandom);
		end
		fill_frame(fb, iv, ov, pick_level(), pick_level(), pick_level(), pick_level(),
			f0, f1, f2, f3);
		if ($urandom_range(0, 3) == 0) begin
			fb[upsdec_pkg::IDX_START] = 8'($urandom);
			fb[FILL_A]                = 8'($urandom);
			fb[FILL_B]                = 8'($urandom);
			fb[upsdec_pkg::IDX_LAST]  = 8'($urandom);
		end
		if (kind >= 86 && kind < 94) begin
			// frame cut short, the next start throws it away
			cut = $urandom_range(1, upsdec_pkg::FRAME_BYTES - 1);
			for (int k = 0; k < cut; k++)
				send_byte(8'($urandom), k == 0);
		end else if (kind >= 94 && kind < 97) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
		end else if (kind >= 97) begin
			// pure noise with scattered start marks
			for (int k = 0; k < upsdec_pkg::FRAME_BYTES; k++)
				send_byte(8'($urandom), $urandom_range(0, 9) == 0);
			return;
		end
		send_frame(fb);
	endtask

	// ---------------------------------------------------------------
	// result sink and checker
	// ---------------------------------------------------------------

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	task automatic note_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
	endtask

	task automatic check_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got)
			note_mismatch(what, want, got);
	endtask

	always @(posedge clk) begin
		decode_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_decodes.size() == 0) begin
				note_mismatch("result with none owed, frame_ok", 0, res_ch.frame_ok);
			end else begin
				want = expected_decodes.pop_front();
				check_field("frame_ok", want.frame_ok, res_ch.frame_ok);
				check_field("input_voltage", want.input_voltage, res_ch.input_voltage);
				check_field("output_voltage", want.output_voltage, res_ch.output_voltage);
				check_field("load_percent", want.load_percent, res_ch.load_percent);
				check_field("battery_charge", want.battery_charge, res_ch.battery_charge);
				check_field("temperature_tenths", want.temperature_tenths,
					res_ch.temperature_tenths);
				check_field("frequency_tenths", want.frequency_tenths,
					res_ch.frequency_tenths);
				check_field("status_bits", want.status_bits, res_ch.status_bits);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		logic [7:0] fb [upsdec_pkg::FRAME_BYTES];
		int         goal;
		arst_n             = 1'b0;
		rx_ch.valid        = 1'b0;
		rx_ch.rx_byte      = 8'h00;
		rx_ch.frame_start  = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.series_mode = MODE_DEFAULT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the first idling mix
		src_idle_pct  = 15;
		snk_stall_pct = 54;
		write_mode(MODE_DEFAULT);
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].mode != cur_mode)
				write_mode(dir_rows[i].mode);
			unique case (dir_rows[i].lead)
				LEAD_STRAY: begin
					send_byte(8'hA5, 1'b0);
				end
				LEAD_RESTART: begin
					for (int k = 0; k < 5; k++)
						send_byte(8'($urandom), k == 0);
				end
				default: begin
				end
			endcase
			fill_frame(fb, dir_rows[i].iv, dir_rows[i].ov, dir_rows[i].ld, dir_rows[i].ch,
				dir_rows[i].tp, dir_rows[i].fq, dir_rows[i].f0, dir_rows[i].f1,
				dir_rows[i].f2, dir_rows[i].f3);
			use_typed   = dir_rows[i].typed;
			typed_value = dir_rows[i].want;
			send_frame(fb);
			use_typed = 1'b0;
		end

		// random phases: sink-heavy stalling, source-heavy idling, then full rate
		for (int p = 0; p < PHASES; p++) begin
			src_idle_pct  = (p < 2) ? 15 : (p < 4) ? 54 : 0;
			snk_stall_pct = (p < 2) ? 54 : (p < 4) ? 15 : 0;
			write_mode((p % 2 == 0) ? MODE_OP : MODE_DEFAULT);
			goal = bytes_taken + RANDOM_ITEMS / PHASES;
			while (bytes_taken < goal)
				send_random_frame();
			// close any open frame so the mode change finds the block idle
			if (rx_pos != 0) begin
				fill_frame(fb, pick_level(), pick_level(), pick_level(), pick_level(),
					pick_level(), pick_level(), 8'h00, 8'hFF, 8'h00, 8'hFF);
				send_frame(fb);
			end
		end

		drain_results();
		if (mismatches == 0 && expected_decodes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
